/* design/efr_pkg.sv */
// Package for the escaped frame receiver: phase states, item kinds,
// configuration register indexes, reset values and the result layout.
// No dependencies.
package efr_pkg;

    // Receive phase, one-hot coded.
    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_READ = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    // Phase as reported in a result.
    localparam logic [1:0] PHASE_WAIT_CODE = 2'd0;
    localparam logic [1:0] PHASE_READ_CODE = 2'd1;
    localparam logic [1:0] PHASE_DONE_CODE = 2'd2;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] MODE_RX      = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [7:0] CFG_HEAD     = 8'd0;
    localparam logic [7:0] CFG_END      = 8'd1;
    localparam logic [7:0] CFG_ESCAPE   = 8'd2;
    localparam logic [7:0] CFG_CAPACITY = 8'd3;

    // Register values after reset.
    localparam logic [7:0] HEAD_RST     = 8'd2;
    localparam logic [7:0] END_RST      = 8'd3;
    localparam logic [7:0] ESCAPE_RST   = 8'd27;
    localparam logic [6:0] CAPACITY_RST = 7'd64;

    // One result, first field in the highest bits.
    typedef struct packed {
        logic       overflowed;
        logic       error;
        logic [7:0] read_data;
        logic [6:0] frame_length;
        logic [1:0] phase;
    } t_result;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT: code = PHASE_WAIT_CODE;
            PH_READ: code = PHASE_READ_CODE;
            PH_DONE: code = PHASE_DONE_CODE;
            default: code = PHASE_WAIT_CODE;
        endcase
        return code;
    endfunction

endpackage

/* design/escaped_frame_receiver.sv */
// A result passes the read stage (store read), then the result queue. Throughput: one item
// per cycle while the queue has room. Input ready depends only on internal registers; a
// three-entry result queue keeps input transfers flowing while a result waits.
// Reset (i_rst_n low, synchronous) clears phase, count, escape and overflow state, the
// pipeline and the queue, and loads the register defaults. The frame store is not
// cleared; bytes beyond the stored count are never returned. Depends on efr_pkg.
module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: rx_byte [7:0], read_index [13:8], reader_room [20:14], zeros [23:21]
    input  logic [23:0] i_s_tdata,
    // tuser: mode [1:0]
    input  logic [1:0]  i_s_tuser,
    // Results.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: phase [1:0], frame_length [8:2], read_data [16:9], error [17],
    // overflowed [18], zeros [23:19]
    output logic [23:0] o_m_tdata,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    // Largest count that the 7-bit length can hold within the store.
    localparam logic [6:0] CAP_MAX = (BUF_DEPTH > 127) ? 7'd127 : 7'(BUF_DEPTH);
    localparam logic [1:0] Q_LAST = 2'd2;

    // Input fields.
    logic [1:0] s_mode;
    logic [7:0] s_rx_byte;
    logic [5:0] s_read_index;
    logic [6:0] s_reader_room;
    logic       s_xfer;

    assign s_mode        = i_s_tuser;
    assign s_rx_byte     = i_s_tdata[7:0];
    assign s_read_index  = i_s_tdata[13:8];
    assign s_reader_room = i_s_tdata[20:14];
    assign s_xfer        = i_s_tvalid && o_s_tready;

    // Configuration registers. Writes are always taken; unknown indexes are dropped.
    logic [7:0] r_head, r_end, r_esc;
    logic [6:0] r_cap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= HEAD_RST;
            r_end  <= END_RST;
            r_esc  <= ESCAPE_RST;
            r_cap  <= CAPACITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEAD:     r_head <= i_cfg_data;
                CFG_END:      r_end  <= i_cfg_data;
                CFG_ESCAPE:   r_esc  <= i_cfg_data;
                CFG_CAPACITY: r_cap  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Frame control state. It is updated at the input transfer, so the next
    // item already sees its effect.
    t_phase     r_phase, n_phase;
    logic [6:0] r_len, n_len;
    logic       r_esc_pend, n_esc_pend;
    logic       r_ovf, n_ovf;

    logic       req_err;
    logic       req_rd_ok;
    logic       mem_we;
    logic [6:0] eff_cap;
    logic [31:0] wr_wide, rd_wide;
    logic [AW-1:0] wr_addr, rd_addr;

    // A capacity above what the store holds saturates to the store size.
    assign eff_cap = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign wr_wide = 32'(r_len);
    assign rd_wide = 32'(s_read_index);
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_addr = rd_wide[AW-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_esc_pend = r_esc_pend;
        n_ovf      = r_ovf;
        req_err    = 1'b0;
        req_rd_ok  = 1'b0;
        mem_we     = 1'b0;
        if (s_xfer) begin
            unique case (s_mode)
                MODE_RX: begin
                    unique case (r_phase)
                        PH_WAIT: begin
                            // A head byte opens a new, empty frame.
                            if (s_rx_byte == r_head) begin
                                n_phase    = PH_READ;
                                n_len      = 7'd0;
                                n_esc_pend = 1'b0;
                                n_ovf      = 1'b0;
                            end
                        end
                        PH_READ: begin
                            if (!r_esc_pend && s_rx_byte == r_esc) begin
                                n_esc_pend = 1'b1;
                            end else if (!r_esc_pend && s_rx_byte == r_end) begin
                                n_phase = PH_DONE;
                            end else begin
                                // Data byte: stored while there is room, else dropped
                                // and the frame is marked as overflowed.
                                if (r_len < eff_cap) begin
                                    mem_we = 1'b1;
                                    n_len  = r_len + 7'd1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                                n_esc_pend = 1'b0;
                            end
                        end
                        PH_DONE: ;
                        default: ;
                    endcase
                end
                MODE_READ: begin
                    req_rd_ok = (rd_wide < 32'(BUF_DEPTH)) && (7'(s_read_index) < r_len);
                end
                MODE_RELEASE: begin
                    if (r_phase != PH_DONE || s_reader_room < r_len) begin
                        req_err = 1'b1;
                    end else begin
                        n_phase    = PH_WAIT;
                        n_len      = 7'd0;
                        n_esc_pend = 1'b0;
                        n_ovf      = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_len      <= 7'd0;
            r_esc_pend <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_esc_pend <= n_esc_pend;
            r_ovf      <= n_ovf;
        end
    end

    // Frame store: one write port at the stored count, one registered read port.
    // A read and a write never come from the same transfer, and a byte written at
    // one edge is readable by the item of the next cycle.
    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= s_rx_byte;
        end
        if (s_xfer) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Read stage: holds the status of the item while the store read completes.
    logic    r_s1_vld;
    logic    r_s1_rd_ok;
    t_result r_s1_res;
    t_result s1_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_rd_ok            <= req_rd_ok;
            r_s1_res.overflowed   <= n_ovf;
            r_s1_res.error        <= req_err;
            r_s1_res.read_data    <= 8'd0;
            r_s1_res.frame_length <= n_len;
            r_s1_res.phase        <= phase_code(n_phase);
        end
    end

    always_comb begin
        s1_res           = r_s1_res;
        s1_res.read_data = r_s1_rd_ok ? r_mem_q : 8'd0;
    end

    // Result queue of three entries. The read stage always drains into it, so
    // input is taken only while the queue plus the read stage hold at most two.
    t_result    r_q [3];
    logic [1:0] r_wp, r_rp, r_q_cnt;
    logic       q_pop;

    assign q_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {5'd0, r_q[r_rp]};
    assign o_s_tready = (r_q_cnt != Q_LAST + 2'd1) && !(r_q_cnt == Q_LAST && r_s1_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_q_cnt <= 2'd0;
        end else begin
            if (r_s1_vld) begin
                r_wp <= (r_wp == Q_LAST) ? 2'd0 : r_wp + 2'd1;
            end
            if (q_pop) begin
                r_rp <= (r_rp == Q_LAST) ? 2'd0 : r_rp + 2'd1;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_s1_vld} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_q[r_wp] <= s1_res;
        end
    end

endmodule

/* design/efr_checker.sv */
// Port-level checker for the escaped frame receiver, bound to the top level.
// Depends on efr_pkg and escaped_frame_receiver.
module efr_checker
    import efr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    t_result res;
    assign res = o_m_tdata[18:0];

    // A stalled result transfer keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Waiting for a head byte always means an empty frame without overflow.
    a_wait_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.phase == PHASE_WAIT_CODE |->
            res.frame_length == 7'd0 && !res.overflowed)
        else $error("waiting phase with stored bytes or overflow");

    // A refused release never carries read data.
    a_err_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.error |-> res.read_data == 8'd0)
        else $error("refused release with read data");

    // No result is offered right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
